>>> rtl/iem_pkg.sv
`default_nettype none
package iem_pkg;

  // Sizes
  localparam int PAGE_BYTES = 16;
  localparam int PAGE_IDX_W = $clog2(PAGE_BYTES);
  localparam int MEM_BYTES  = 512;
  localparam int ADDR_W     = 9;
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'(MEM_BYTES - 1);

  // Register reset values
  localparam logic [4:0]  DEVICE_CODE_RST = 5'd20;
  localparam logic [15:0] WAIT_TICKS_RST  = 16'd1000;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_NO_DEV   = 3'd1;
  localparam logic [2:0] STS_NO_ADDR  = 3'd2;
  localparam logic [2:0] STS_NO_DATA  = 3'd3;
  localparam logic [2:0] STS_CROSSING = 3'd4;

  // Register map indexes
  localparam logic REG_DEVICE_CODE = 1'b0;
  localparam logic REG_WAIT_TICKS  = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] mem_address;
    logic [7:0]        byte_count;
    logic [7:0]        wr_data;
    logic              sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       byte_valid;
    logic [7:0] read_data;
    logic       last_byte;
    logic       done_res;
    logic [2:0] status;
    logic       busy_res;
  } rsp_t;

  typedef struct packed {
    logic [4:0]  device_code;
    logic [15:0] write_wait_ticks;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/iem_cfg_regs.sv
`default_nettype none
module iem_cfg_regs
  import iem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_code      <= DEVICE_CODE_RST;
      cfg.write_wait_ticks <= WAIT_TICKS_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DEVICE_CODE: cfg.device_code      <= pwdata[4:0];
        REG_WAIT_TICKS:  cfg.write_wait_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEVICE_CODE: prdata = {27'd0, cfg.device_code};
      REG_WAIT_TICKS:  prdata = {16'd0, cfg.write_wait_ticks};
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/iem_bus_fsm.sv
`default_nettype none
module iem_bus_fsm
  import iem_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic acc,
  input  wire cmd_t cmd,
  input  wire cfg_t cfg,
  output rsp_t      rsp_next
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_SEND, PH_GACK, PH_READ, PH_SACK, PH_STOP, PH_WAIT
  } phase_t;

  typedef enum logic [1:0] {
    SG_DEVW, SG_ADDR, SG_DATA, SG_DEVR
  } stage_t;

  phase_t                phase, phase_next;
  stage_t                stage, stage_next;
  logic [1:0]            sub_step, sub_step_next;
  logic [2:0]            end_code, end_code_next;
  logic                  reading, reading_next;
  logic                  scl_q, scl_q_next;
  logic                  sda_q, sda_q_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic [ADDR_W-1:0]     cur_address, cur_address_next;
  logic [7:0]            bytes_left, bytes_left_next;
  logic [15:0]           wait_count, wait_count_next;
  logic [PAGE_IDX_W-1:0] load_index, load_index_next;

  logic [7:0]            page_buffer [PAGE_BYTES];
  logic                  pb_we;
  logic [PAGE_IDX_W-1:0] pb_idx;
  logic [7:0]            pb_data;

  logic [ADDR_W-1:0]     addr_in;
  logic [ADDR_W:0]       last_addr;
  logic                  crossing;
  logic [7:0]            shift_in;
  logic [7:0]            dev_byte;

  assign addr_in   = cmd.mem_address & ADDR_MASK;
  assign last_addr = {1'b0, addr_in} + {2'b00, cmd.byte_count} - (ADDR_W+1)'(1);
  assign crossing  = (({1'b0, addr_in} >> PAGE_IDX_W) != (last_addr >> PAGE_IDX_W));
  assign shift_in  = {shift_reg[6:0], cmd.sda_sample};
  // device byte: code, block bit (upper block bit always 0 at 9 address bits), r/w
  assign dev_byte  = {cfg.device_code, 1'b0, cur_address[8], stage == SG_DEVR};

  // next data byte comes after the index steps on, the first one at the index itself
  assign pb_idx  = (stage == SG_DATA) ? load_index + PAGE_IDX_W'(1) : load_index;
  assign pb_data = page_buffer[pb_idx];

  always_comb begin
    phase_next       = phase;
    stage_next       = stage;
    sub_step_next    = sub_step;
    end_code_next    = end_code;
    reading_next     = reading;
    scl_q_next       = scl_q;
    sda_q_next       = sda_q;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    cur_address_next = cur_address;
    bytes_left_next  = bytes_left;
    wait_count_next  = wait_count;
    load_index_next  = load_index;
    pb_we            = 1'b0;
    rsp_next         = '0;

    if (acc) begin
      if (cmd.operation == OP_TICK) begin
        unique case (phase)
          PH_START: begin
            scl_q_next = 1'b1;
            if (sub_step == 2'd0) begin
              sda_q_next    = 1'b1;
              sub_step_next = 2'd1;
            end else begin
              sda_q_next     = 1'b0;
              shift_reg_next = dev_byte;
              bit_index_next = 3'd7;
              sub_step_next  = 2'd0;
              phase_next     = PH_SEND;
            end
          end
          PH_SEND: begin
            if (sub_step == 2'd0) begin
              scl_q_next    = 1'b0;
              sub_step_next = 2'd1;
            end else if (sub_step == 2'd1) begin
              sda_q_next    = shift_reg[7];
              sub_step_next = 2'd2;
            end else begin
              scl_q_next     = 1'b1;
              shift_reg_next = {shift_reg[6:0], 1'b0};
              sub_step_next  = 2'd0;
              if (bit_index == 3'd0) begin
                phase_next = PH_GACK;
              end else begin
                bit_index_next = bit_index - 3'd1;
              end
            end
          end
          PH_GACK: begin
            sda_q_next = 1'b1;
            if (sub_step == 2'd0) begin
              scl_q_next    = 1'b0;
              sub_step_next = 2'd1;
            end else begin
              scl_q_next    = 1'b1;
              sub_step_next = 2'd0;
              if (cmd.sda_sample) begin
                phase_next = PH_STOP;
                unique case (stage)
                  SG_ADDR: end_code_next = STS_NO_ADDR;
                  SG_DATA: end_code_next = STS_NO_DATA;
                  default: end_code_next = STS_NO_DEV;
                endcase
              end else begin
                unique case (stage)
                  SG_DEVW: begin
                    shift_reg_next = cur_address[7:0];
                    bit_index_next = 3'd7;
                    stage_next     = SG_ADDR;
                    phase_next     = PH_SEND;
                  end
                  SG_ADDR: begin
                    if (reading) begin
                      stage_next = SG_DEVR;
                      phase_next = PH_START;
                    end else begin
                      shift_reg_next = pb_data;
                      bit_index_next = 3'd7;
                      stage_next     = SG_DATA;
                      phase_next     = PH_SEND;
                    end
                  end
                  SG_DATA: begin
                    bytes_left_next = bytes_left - 8'd1;
                    load_index_next = load_index + PAGE_IDX_W'(1);
                    if (bytes_left == 8'd1) begin
                      end_code_next = STS_OK;
                      phase_next    = PH_STOP;
                    end else begin
                      shift_reg_next = pb_data;
                      bit_index_next = 3'd7;
                      phase_next     = PH_SEND;
                    end
                  end
                  SG_DEVR: begin
                    shift_reg_next = 8'd0;
                    bit_index_next = 3'd7;
                    phase_next     = PH_READ;
                  end
                  default: ;
                endcase
              end
            end
          end
          PH_READ: begin
            sda_q_next = 1'b1;
            if (sub_step == 2'd0) begin
              scl_q_next    = 1'b0;
              sub_step_next = 2'd1;
            end else begin
              scl_q_next     = 1'b1;
              shift_reg_next = shift_in;
              sub_step_next  = 2'd0;
              if (bit_index == 3'd0) begin
                rsp_next.byte_valid = 1'b1;
                rsp_next.read_data  = shift_in;
                rsp_next.last_byte  = (bytes_left == 8'd1);
                phase_next          = PH_SACK;
              end else begin
                bit_index_next = bit_index - 3'd1;
              end
            end
          end
          PH_SACK: begin
            if (sub_step == 2'd0) begin
              scl_q_next    = 1'b0;
              sub_step_next = 2'd1;
            end else if (sub_step == 2'd1) begin
              sda_q_next    = (bytes_left == 8'd1);
              sub_step_next = 2'd2;
            end else begin
              scl_q_next      = 1'b1;
              bytes_left_next = bytes_left - 8'd1;
              sub_step_next   = 2'd0;
              if (bytes_left == 8'd1) begin
                end_code_next = STS_OK;
                phase_next    = PH_STOP;
              end else begin
                shift_reg_next = 8'd0;
                bit_index_next = 3'd7;
                phase_next     = PH_READ;
              end
            end
          end
          PH_STOP: begin
            scl_q_next = 1'b1;
            if (sub_step == 2'd0) begin
              sda_q_next    = 1'b0;
              sub_step_next = 2'd1;
            end else begin
              sda_q_next = 1'b1;
              if (end_code == STS_OK && !reading && cfg.write_wait_ticks != 16'd0) begin
                wait_count_next = cfg.write_wait_ticks;
                phase_next      = PH_WAIT;
              end else begin
                rsp_next.done_res = 1'b1;
                rsp_next.status   = end_code;
                phase_next        = PH_IDLE;
                load_index_next   = '0;
              end
            end
          end
          PH_WAIT: begin
            scl_q_next      = 1'b1;
            sda_q_next      = 1'b1;
            wait_count_next = wait_count - 16'd1;
            if (wait_count == 16'd1) begin
              rsp_next.done_res = 1'b1;
              rsp_next.status   = end_code;
              phase_next        = PH_IDLE;
              load_index_next   = '0;
            end
          end
          default: ;
        endcase
      end else if (phase == PH_IDLE) begin
        if (cmd.operation == OP_LOAD) begin
          pb_we           = 1'b1;
          load_index_next = load_index + PAGE_IDX_W'(1);
        end else begin
          load_index_next  = '0;
          reading_next     = (cmd.operation == OP_READ);
          cur_address_next = addr_in;
          bytes_left_next  = cmd.byte_count;
          if (cmd.byte_count == 8'd0) begin
            end_code_next     = STS_OK;
            rsp_next.done_res = 1'b1;
            rsp_next.status   = STS_OK;
          end else if (cmd.operation == OP_WRITE && crossing) begin
            end_code_next     = STS_CROSSING;
            rsp_next.done_res = 1'b1;
            rsp_next.status   = STS_CROSSING;
          end else begin
            stage_next    = SG_DEVW;
            sub_step_next = 2'd0;
            end_code_next = STS_OK;
            phase_next    = PH_START;
          end
        end
      end
    end

    rsp_next.scl_level   = scl_q_next;
    rsp_next.sda_release = sda_q_next;
    rsp_next.busy_res    = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      stage       <= SG_DEVW;
      sub_step    <= 2'd0;
      end_code    <= STS_OK;
      reading     <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      bit_index   <= 3'd0;
      shift_reg   <= 8'd0;
      cur_address <= '0;
      bytes_left  <= 8'd0;
      wait_count  <= 16'd0;
      load_index  <= '0;
    end else begin
      phase       <= phase_next;
      stage       <= stage_next;
      sub_step    <= sub_step_next;
      end_code    <= end_code_next;
      reading     <= reading_next;
      scl_q       <= scl_q_next;
      sda_q       <= sda_q_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      cur_address <= cur_address_next;
      bytes_left  <= bytes_left_next;
      wait_count  <= wait_count_next;
      load_index  <= load_index_next;
    end
  end

  // page buffer: no reset, contents defined once loaded
  always_ff @(posedge clk) begin
    if (pb_we) begin
      page_buffer[load_index] <= cmd.wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/iem_rsp_buf.sv
`default_nettype none
module iem_rsp_buf
  import iem_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rsp_t push_data,
  output logic      full,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  rsp_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign rsp_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = rsp_valid && !rsp_stall;
  assign rsp       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/i2c_eeprom_master_unit.sv
// Each command or tick transfer forms a result that is registered into the result buffer.
// Throughput: one transfer per clock unless stalled; exactly one result per transfer.
// A two-entry result buffer parts the sides; cmd_stall rises only when both are full.
// Reset (rst, synchronous, active high): bus idle with SCL high and SDA released,
// registers back to device code 10100 and a 1000-tick write wait; page buffer not cleared.
`default_nettype none
module i2c_eeprom_master_unit
  import iem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // command / tick channel
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  // result channel
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  rsp_t rsp_next;
  logic acc;
  logic buf_full;

  // A command transfer is taken whenever the result buffer has room; the bus
  // engine updates its state and forms the result in the same cycle.
  assign cmd_stall = buf_full;
  assign acc       = cmd_valid && !cmd_stall;

  // Device code and write-cycle wait registers
  iem_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Start / bit / ack / stop sequencer, page buffer and read shifter
  iem_bus_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .cmd      (cmd),
    .cfg      (cfg),
    .rsp_next (rsp_next)
  );

  // Result buffer: lets new ticks in while an earlier result waits
  iem_rsp_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_data (rsp_next),
    .full      (buf_full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTH
  // a stalled command side means results are pending
  a_stall_has_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> rsp_valid)
    else $error("command stalled with no result pending");

  // a finished command leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.done_res) |-> !rsp.busy_res)
    else $error("done reported while still busy");

  // a read byte lands on an SCL high tick inside a command
  a_byte_in_cmd: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.byte_valid) |-> (rsp.busy_res && rsp.scl_level && !rsp.done_res))
    else $error("read byte outside a running read");

  // a non-zero status only comes with done
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != STS_OK) |-> rsp.done_res)
    else $error("status without done");
`endif

endmodule
`default_nettype wire

>>> bench/i2c_eeprom_master_unit_tb.sv
module i2c_eeprom_master_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iem_pkg::*;

  // Bus sequencer phases and the ack stage being served, as the shadow sees them
  typedef enum bit [2:0] {
    M_IDLE, M_START, M_SEND, M_GACK, M_READ, M_SACK, M_STOP, M_WAIT
  } bus_phase_t;

  typedef enum bit [1:0] {
    STG_DEV_WR, STG_WORD, STG_DATA, STG_DEV_RD
  } ack_stage_t;

  // Everything the master keeps between transfers, plus the bus levels it drives
  typedef struct packed {
    bus_phase_t      phase;
    ack_stage_t      stage;
    bit [1:0]        sub;
    bit [2:0]        bit_idx;
    bit [7:0]        shifter;
    bit [8:0]        addr;
    bit [7:0]        left;
    bit [15:0]       wait_cnt;
    bit [3:0]        load_idx;
    bit [2:0]        end_code;
    bit              scl;
    bit              sda;
    bit              reading;
    bit [15:0][7:0]  page_buf;
  } master_shadow_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Two shadows: one steers the stimulus as it is planned, the other predicts
  // results as transfers are actually accepted.
  master_shadow_t plan_shadow;
  master_shadow_t master_shadow;
  cfg_t           cfg_now;

  cmd_t cmds_to_send[$];     // planned ticks and commands, not yet offered
  rsp_t bus_results_due[$];  // predicted bus levels and results, oldest first

  int planned;
  int mismatches;
  int rsp_count;

  // sender side idling
  int gap_left;
  int tx_mode_left;
  bit tx_calm;

  // receiver side idling
  int stall_left;
  int rx_mode_left;
  bit rx_calm;
  bit long_hold_done;

  i2c_eeprom_master_unit uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Shadow of the master
  // ------------------------------------------------------------------

  function automatic master_shadow_t shadow_at_reset();
    master_shadow_t m;
    m = '0;
    m.phase = M_IDLE;
    m.stage = STG_DEV_WR;
    m.scl = 1'b1;
    m.sda = 1'b1;
    return m;
  endfunction

  function automatic void send_byte(inout master_shadow_t m, input bit [7:0] b,
                                    input ack_stage_t stg);
    m.shifter = b;
    m.bit_idx = 3'd7;
    m.sub = 2'd0;
    m.stage = stg;
    m.phase = M_SEND;
  endfunction

  function automatic void stop_with(inout master_shadow_t m, input bit [2:0] code);
    m.end_code = code;
    m.sub = 2'd0;
    m.phase = M_STOP;
  endfunction

  function automatic void finish_cmd(inout master_shadow_t m, inout rsp_t r);
    r.done_res = 1'b1;
    r.status = m.end_code;
    m.phase = M_IDLE;
    m.load_idx = '0;
  endfunction

  // One accepted transfer in, one result out
  function automatic void eeprom_master_step(inout master_shadow_t m, input cfg_t cf,
                                             input cmd_t c, output rsp_t r);
    int first_page;
    int last_page;
    r = '0;
    if (c.operation == OP_TICK) begin
      case (m.phase)
        M_START: begin
          m.scl = 1'b1;
          if (m.sub == 0) begin
            m.sda = 1'b1;
            m.sub = 2'd1;
          end else begin
            // block bit sits just above the r/w bit
            m.sda = 1'b0;
            send_byte(m, {cf.device_code, 1'b0, m.addr[8], m.stage == STG_DEV_RD}, m.stage);
          end
        end
        M_SEND: begin
          if (m.sub == 0) begin
            m.scl = 1'b0;
            m.sub = 2'd1;
          end else if (m.sub == 1) begin
            m.sda = m.shifter[7];
            m.sub = 2'd2;
          end else begin
            m.scl = 1'b1;
            m.shifter = {m.shifter[6:0], 1'b0};
            m.sub = 2'd0;
            if (m.bit_idx == 0) m.phase = M_GACK;
            else m.bit_idx = m.bit_idx - 1'b1;
          end
        end
        M_GACK: begin
          m.sda = 1'b1;
          if (m.sub == 0) begin
            m.scl = 1'b0;
            m.sub = 2'd1;
          end else begin
            m.scl = 1'b1;
            if (c.sda_sample) begin
              stop_with(m, m.stage == STG_WORD ? STS_NO_ADDR :
                           m.stage == STG_DATA ? STS_NO_DATA : STS_NO_DEV);
            end else begin
              case (m.stage)
                STG_DEV_WR: send_byte(m, m.addr[7:0], STG_WORD);
                STG_WORD: begin
                  if (m.reading) begin
                    // repeated start, then the device read address
                    m.stage = STG_DEV_RD;
                    m.sub = 2'd0;
                    m.phase = M_START;
                  end else begin
                    send_byte(m, m.page_buf[m.load_idx], STG_DATA);
                  end
                end
                STG_DATA: begin
                  m.left = m.left - 1'b1;
                  m.load_idx = m.load_idx + 1'b1;
                  if (m.left == 0) stop_with(m, STS_OK);
                  else send_byte(m, m.page_buf[m.load_idx], STG_DATA);
                end
                default: begin
                  m.shifter = '0;
                  m.bit_idx = 3'd7;
                  m.sub = 2'd0;
                  m.phase = M_READ;
                end
              endcase
            end
          end
        end
        M_READ: begin
          m.sda = 1'b1;
          if (m.sub == 0) begin
            m.scl = 1'b0;
            m.sub = 2'd1;
          end else begin
            m.scl = 1'b1;
            m.shifter = {m.shifter[6:0], c.sda_sample};
            m.sub = 2'd0;
            if (m.bit_idx == 0) begin
              r.byte_valid = 1'b1;
              r.read_data = m.shifter;
              r.last_byte = (m.left == 1);
              m.phase = M_SACK;
            end else begin
              m.bit_idx = m.bit_idx - 1'b1;
            end
          end
        end
        M_SACK: begin
          if (m.sub == 0) begin
            m.scl = 1'b0;
            m.sub = 2'd1;
          end else if (m.sub == 1) begin
            // ack every byte but the last
            m.sda = (m.left == 1);
            m.sub = 2'd2;
          end else begin
            m.scl = 1'b1;
            m.left = m.left - 1'b1;
            m.sub = 2'd0;
            if (m.left == 0) begin
              stop_with(m, STS_OK);
            end else begin
              m.shifter = '0;
              m.bit_idx = 3'd7;
              m.phase = M_READ;
            end
          end
        end
        M_STOP: begin
          m.scl = 1'b1;
          if (m.sub == 0) begin
            m.sda = 1'b0;
            m.sub = 2'd1;
          end else begin
            m.sda = 1'b1;
            if (m.end_code == STS_OK && !m.reading && cf.write_wait_ticks != 0) begin
              m.wait_cnt = cf.write_wait_ticks;
              m.phase = M_WAIT;
            end else begin
              finish_cmd(m, r);
            end
          end
        end
        M_WAIT: begin
          m.scl = 1'b1;
          m.sda = 1'b1;
          m.wait_cnt = m.wait_cnt - 1'b1;
          if (m.wait_cnt == 0) finish_cmd(m, r);
        end
        default: ;  // idle tick: bus levels only
      endcase
    end else if (m.phase == M_IDLE) begin
      if (c.operation == OP_LOAD) begin
        m.page_buf[m.load_idx] = c.wr_data;
        m.load_idx = m.load_idx + 1'b1;
      end else begin
        m.load_idx = '0;
        m.reading = (c.operation == OP_READ);
        m.addr = c.mem_address;
        m.left = c.byte_count;
        first_page = int'(c.mem_address) / PAGE_BYTES;
        last_page = (int'(c.mem_address) + int'(c.byte_count) - 1) / PAGE_BYTES;
        if (c.byte_count == 0) begin
          m.end_code = STS_OK;
          finish_cmd(m, r);
        end else if (!m.reading && first_page != last_page) begin
          m.end_code = STS_CROSSING;
          finish_cmd(m, r);
        end else begin
          m.stage = STG_DEV_WR;
          m.sub = 2'd0;
          m.end_code = STS_OK;
          m.phase = M_START;
        end
      end
    end
    // commands arriving while busy fall through untouched
    r.scl_level = m.scl;
    r.sda_release = m.sda;
    r.busy_res = (m.phase != M_IDLE);
  endfunction

  // ------------------------------------------------------------------
  // Stimulus planning
  // ------------------------------------------------------------------

  function automatic cmd_t make_cmd(logic [1:0] op, logic [8:0] addr, logic [7:0] count,
                                    logic [7:0] data);
    cmd_t c;
    c.operation = op;
    c.mem_address = addr;
    c.byte_count = count;
    c.wr_data = data;
    c.sda_sample = 1'($urandom);
    return c;
  endfunction

  function automatic void queue_cmd(cmd_t c);
    rsp_t unused;
    eeprom_master_step(plan_shadow, cfg_now, c, unused);
    cmds_to_send.push_back(c);
    planned++;
  endfunction

  function automatic void load_bytes(int n);
    for (int i = 0; i < n; i++)
      queue_cmd(make_cmd(OP_LOAD, 9'($urandom), 8'($urandom), 8'($urandom)));
  endfunction

  // Issue a command and tick it through to idle. The slave's acks are forced
  // low except on ack number nack_at, or at random when nack_at is zero.
  function automatic void run_command(logic [1:0] op, logic [8:0] addr, logic [7:0] count,
                                      int nack_at, int nack_pct);
    int acks;
    cmd_t c;
    acks = 0;
    queue_cmd(make_cmd(op, addr, count, 8'($urandom)));
    while (plan_shadow.phase != M_IDLE) begin
      c = make_cmd(OP_TICK, 9'($urandom), 8'($urandom), 8'($urandom));
      if (plan_shadow.phase == M_GACK && plan_shadow.sub == 1) begin
        acks++;
        c.sda_sample = (nack_at != 0) ? (acks == nack_at) : ($urandom_range(99) < nack_pct);
      end else if ($urandom_range(99) < 4) begin
        // stray command mid-transfer; the master must drop it
        c.operation = 2'($urandom_range(1, 3));
      end
      queue_cmd(c);
    end
  endfunction

  function automatic void random_command();
    int r;
    int n;
    logic [8:0] addr;
    logic [7:0] count;
    r = $urandom_range(99);
    addr = 9'($urandom);
    if (r < 40) begin
      // fill some of the page buffer, then write it out, mostly within a page
      n = $urandom_range(1, PAGE_BYTES);
      load_bytes(n);
      if ($urandom_range(9) != 0) count = 8'($urandom_range(1, PAGE_BYTES - addr[3:0]));
      else count = 8'($urandom);
      run_command(OP_WRITE, addr, count, 0, 4);
    end else if (r < 82) begin
      count = ($urandom_range(9) != 0) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(7, 40));
      run_command(OP_READ, addr, count, 0, 4);
    end else if (r < 92) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        queue_cmd(make_cmd(OP_TICK, 9'($urandom), 8'($urandom), 8'($urandom)));
    end else if (r < 96) begin
      run_command($urandom_range(1) ? OP_WRITE : OP_READ, addr, 8'd0, 0, 4);
    end else begin
      // too long for any page
      run_command(OP_WRITE, addr, 8'($urandom_range(17, 255)), 0, 4);
    end
  endfunction

  function automatic void random_phase(int n);
    int target;
    target = planned + n;
    while (planned < target) random_command();
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(6, 30);
  endfunction

  // ------------------------------------------------------------------
  // Register port and checking helpers
  // ------------------------------------------------------------------

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [4:0] code, logic [15:0] ticks);
    write_reg(REG_DEVICE_CODE, 32'(code));
    write_reg(REG_WAIT_TICKS, 32'(ticks));
    cfg_now.device_code = code;
    cfg_now.write_wait_ticks = ticks;
  endtask

  // Sender stops until every predicted result has been taken.
  task automatic drain_bus();
    while (cmds_to_send.size() != 0 || cmd_valid || bus_results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at result %0d: %s", rsp_count, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // ------------------------------------------------------------------
  // Command side: one transfer per handshake, gaps in bursts
  // ------------------------------------------------------------------

  always @(posedge clk) begin : drive
    cmd_t nxt;
    logic nxt_valid;
    rsp_t due;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      nxt = cmd;
      nxt_valid = cmd_valid;
      if (cmd_valid && !cmd_stall) begin
        // transfer taken: predict its result now, in acceptance order
        eeprom_master_step(master_shadow, cfg_now, cmd, due);
        bus_results_due.push_back(due);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmds_to_send.size() != 0) begin
          nxt = cmds_to_send.pop_front();
          nxt_valid = 1'b1;
          if (tx_mode_left == 0) begin
            tx_calm = ($urandom_range(2) == 0);
            tx_mode_left = $urandom_range(20, 200);
          end
          tx_mode_left--;
          gap_left = tx_calm ? 0 : idle_length();
        end
      end
      // single update per edge; a held payload stays as it was
      cmd_valid <= nxt_valid;
      cmd <= nxt;
    end
  end

  // ------------------------------------------------------------------
  // Result side: stall pattern, with one forced long hold-off so the
  // result buffer fills and the command side backs up.
  // ------------------------------------------------------------------

  always @(posedge clk) begin : backpressure
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_calm = ($urandom_range(2) == 0);
        rx_mode_left = $urandom_range(50, 400);
      end
      rx_mode_left--;
      if (stall_left == 0) begin
        if (!long_hold_done && rsp_count >= 300) begin
          stall_left = 200;
          long_hold_done = 1'b1;
        end else if ($urandom_range(4999) == 0) begin
          stall_left = $urandom_range(40, 150);
        end else if (!rx_calm && $urandom_range(3) == 0) begin
          stall_left = idle_length();
        end
      end
      if (stall_left != 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : observe
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count++;
      if (bus_results_due.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = bus_results_due.pop_front();
        check_field("scl_level", rsp.scl_level, want.scl_level);
        check_field("sda_release", rsp.sda_release, want.sda_release);
        check_field("byte_valid", rsp.byte_valid, want.byte_valid);
        check_field("read_data", rsp.read_data, want.read_data);
        check_field("last_byte", rsp.last_byte, want.last_byte);
        check_field("done_res", rsp.done_res, want.done_res);
        check_field("status", rsp.status, want.status);
        check_field("busy_res", rsp.busy_res, want.busy_res);
      end
    end
  end

  // ------------------------------------------------------------------
  // Sequence of phases
  // ------------------------------------------------------------------

  initial begin : run
    cmd_t c;
    cfg_now = '{device_code: DEVICE_CODE_RST, write_wait_ticks: WAIT_TICKS_RST};
    plan_shadow = shadow_at_reset();
    master_shadow = shadow_at_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, at reset settings. Idle ticks with both line levels.
    for (int b = 0; b < 2; b++) begin
      c = make_cmd(OP_TICK, 9'($urandom), 8'($urandom), 8'($urandom));
      c.sda_sample = b[0];
      queue_cmd(c);
    end
    // Fill the whole page buffer and wrap the load pointer once; no later
    // write can then send an entry that was never loaded.
    queue_cmd(make_cmd(OP_LOAD, '0, '0, 8'h00));
    queue_cmd(make_cmd(OP_LOAD, '1, 8'hff, 8'hff));
    load_bytes(PAGE_BYTES - 1);
    run_command(OP_WRITE, 9'h000, 8'd0, 0, 0);    // empty write
    run_command(OP_READ, 9'h1ff, 8'd0, 0, 0);     // empty read
    run_command(OP_WRITE, 9'h00f, 8'd2, 0, 0);    // straddles a page boundary
    run_command(OP_WRITE, 9'h001, 8'd255, 0, 0);  // longest count, crossing
    drain_bus();

    // short write-cycle wait from here on, reset device code kept
    set_config(DEVICE_CODE_RST, 16'd5);
    run_command(OP_WRITE, 9'h100, 8'd16, 0, 0);   // full page, upper block, write wait
    run_command(OP_READ, 9'h1ff, 8'd1, 0, 0);     // single byte, top address
    run_command(OP_READ, 9'h000, 8'd8, 0, 0);     // several acked bytes
    run_command(OP_WRITE, 9'h1f3, 8'd3, 1, 0);    // no ack on device address
    run_command(OP_WRITE, 9'h1f3, 8'd3, 2, 0);    // no ack on word address
    run_command(OP_WRITE, 9'h1f3, 8'd3, 4, 0);    // no ack on second data byte
    run_command(OP_READ, 9'h0a0, 8'd2, 1, 0);     // no ack on device write address
    run_command(OP_READ, 9'h0a0, 8'd2, 2, 0);     // no ack on word address
    run_command(OP_READ, 9'h1a0, 8'd2, 3, 0);     // no ack after repeated start
    drain_bus();

    // Random phases across register settings, low and high extremes included
    set_config(5'd0, 16'd0);
    random_phase(60);
    drain_bus();

    set_config(5'd31, 16'd3);
    random_phase(60);
    drain_bus();

    set_config(5'($urandom), 16'($urandom_range(1, 8)));
    random_phase(60);
    drain_bus();

    // longest write-cycle wait set; a refused write skips the wait
    set_config(5'($urandom), 16'hffff);
    load_bytes(2);
    run_command(OP_WRITE, 9'h0a3, 8'd2, 1, 0);
    drain_bus();

    set_config(DEVICE_CODE_RST, 16'd1);
    random_phase(60);
    drain_bus();

    if (mismatches == 0 && bus_results_due.size() == 0) begin
      $display("i2c_eeprom_master_unit_tb OK");
    end else begin
      $display("i2c_eeprom_master_unit_tb NOT OK");
    end
    $finish;
  end

  // Slowest correct run is roughly 2k transfers, each with a random gap and a
  // random stall, plus the long holds. Allow several times that.
  initial begin : watchdog
    #10ms;
    $display("i2c_eeprom_master_unit_tb NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/iem_pkg.sv
rtl/iem_cfg_regs.sv
rtl/iem_bus_fsm.sv
rtl/iem_rsp_buf.sv
rtl/i2c_eeprom_master_unit.sv
bench/i2c_eeprom_master_unit_tb.sv
